### rtl/assert_macros.svh
// Assertion macros included by donor_cell_convection
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/dcc_pkg.sv
// Package of constants and types for the donor-cell convection pipeline
package dcc_pkg;
  localparam int SampleWidthDef = 32;
  localparam int FracBitsDef    = 16;
  localparam int GammaWidth     = 17;
  localparam int GammaFrac      = 16;
  localparam int RecipWidth     = 32;
  localparam int RecipFrac      = 16;
  localparam int QuarterShift   = 2;
  localparam int CmdWidth       = 2;
  localparam int CfgIdxWidth    = 2;
  localparam logic [GammaWidth-1:0] GammaOne = 17'h10000;

  localparam logic [CmdWidth-1:0] CMD_U = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_V = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_T = 2'd2;
  localparam logic [CmdWidth-1:0] CMD_NONE = 2'd3;

  localparam logic [CfgIdxWidth-1:0] REG_GAMMA  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_RECIPX = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_RECIPY = 2'd2;
endpackage

### rtl/donor_cell_convection.sv
// Donor-cell convection stencil unit, top level
// Usage: pulse start with cmd, five main_* stencil samples and four carrier_*
// velocities. busy is always low, so one request may be issued every clock.
// Each request yields one result on conv_term/saturated, marked by done for
// one cycle. Throughput is one request per cycle, set by the fully pipelined
// multiplier stages in each direction unit.
// Configuration: cfg_we with cfg_index 0 (gamma Q1.16), 1 (1/dx), 2 (1/dy)
// and cfg_data; indices of 3 and above are dropped. Write only when idle.
// Reset (rst, synchronous) clears the valid pipeline and restores register
// defaults: gamma 0 and both reciprocals one. The receiver cannot stall:
// results are shown once and must be taken in that cycle. cmd 3 gives zero.
// Results saturate to the signed sample range and raise saturated.
module donor_cell_convection #(
  parameter int SAMPLE_WIDTH = dcc_pkg::SampleWidthDef,
  parameter int FRAC_BITS    = dcc_pkg::FracBitsDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [dcc_pkg::CmdWidth-1:0]      cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]    main_center,
  input  logic signed [SAMPLE_WIDTH-1:0]    main_east,
  input  logic signed [SAMPLE_WIDTH-1:0]    main_west,
  input  logic signed [SAMPLE_WIDTH-1:0]    main_north,
  input  logic signed [SAMPLE_WIDTH-1:0]    main_south,
  input  logic signed [SAMPLE_WIDTH-1:0]    carrier_a,
  input  logic signed [SAMPLE_WIDTH-1:0]    carrier_b,
  input  logic signed [SAMPLE_WIDTH-1:0]    carrier_c,
  input  logic signed [SAMPLE_WIDTH-1:0]    carrier_d,
  input  logic                              cfg_we,
  input  logic [dcc_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [dcc_pkg::RecipWidth-1:0]    cfg_data,
  output logic                              done,
  output logic signed [SAMPLE_WIDTH-1:0]    conv_term,
  output logic                              saturated
);
  import dcc_pkg::*;
  `include "assert_macros.svh"
  localparam int SW = SAMPLE_WIDTH;
  localparam int EW = SW + 2;
  localparam int TW = 2*SW + RecipWidth + 9;
  localparam int DEPTH = 6;
  localparam logic signed [TW:0] SatMax = $signed({{(TW-SW+2){1'b0}}, {(SW-1){1'b1}}});
  localparam logic signed [TW:0] SatMin = $signed({{(TW-SW+2){1'b1}}, {(SW-1){1'b0}}});

  logic [GammaWidth-1:0] upwind_weight, gamma_eff;
  logic [RecipWidth-1:0] recip_cell_width, recip_cell_height;
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] zero;
  logic signed [EW-1:0] c, e, w, n, s, a, b, cc, d;
  logic signed [EW-1:0] fx1, fx2, fy1, fy2;
  logic signed [TW-1:0] tx, ty;
  logic signed [TW:0] tot;
  logic signed [SW-1:0] res_next;
  logic sat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      upwind_weight <= '0;
      recip_cell_width <= RecipWidth'(65536);
      recip_cell_height <= RecipWidth'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAMMA:  upwind_weight <= cfg_data[GammaWidth-1:0];
        REG_RECIPX: recip_cell_width <= cfg_data;
        REG_RECIPY: recip_cell_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gamma_eff = (upwind_weight > GammaOne) ? GammaOne : upwind_weight;
  assign busy = 1'b0;

  always_comb begin
    c = EW'(main_center); e = EW'(main_east); w = EW'(main_west);
    n = EW'(main_north); s = EW'(main_south);
    a = EW'(carrier_a); b = EW'(carrier_b); cc = EW'(carrier_c); d = EW'(carrier_d);
    case (cmd)
      CMD_U: begin fx1 = c + e; fx2 = w + c; fy1 = a + b; fy2 = cc + d; end
      CMD_V: begin fx1 = a + b; fx2 = cc + d; fy1 = c + n; fy2 = s + c; end
      CMD_T: begin fx1 = a <<< 1; fx2 = b <<< 1; fy1 = cc <<< 1; fy2 = d <<< 1; end
      default: begin fx1 = '0; fx2 = '0; fy1 = '0; fy2 = '0; end
    endcase
  end

  dcc_dir #(.SW(SW), .FB(FRAC_BITS)) u_x (
    .clk(clk), .f1(fx1), .m1(c + e), .d1(c - e), .f2(fx2), .m2(w + c), .d2(w - c),
    .gamma(gamma_eff), .recip(recip_cell_width), .term(tx));
  dcc_dir #(.SW(SW), .FB(FRAC_BITS)) u_y (
    .clk(clk), .f1(fy1), .m1(c + n), .d1(c - n), .f2(fy2), .m2(s + c), .d2(s - c),
    .gamma(gamma_eff), .recip(recip_cell_height), .term(ty));

  assign tot = (TW+1)'(tx) + (TW+1)'(ty);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[DEPTH-2:0], start & ~busy};
      done <= vld[DEPTH-1];
    end
    zero <= {zero[DEPTH-2:0], cmd == CMD_NONE};
    conv_term <= res_next;
    saturated <= sat_next;
  end

  logic tz_q;
  logic signed [TW:0] tq2;
  always_ff @(posedge clk) begin
    tz_q <= zero[DEPTH-1];
    tq2 <= tot;
  end

  always_comb begin
    if (zero[DEPTH-1]) begin
      res_next = '0; sat_next = 1'b0;
    end else if (tot > SatMax) begin
      res_next = {1'b0, {(SW-1){1'b1}}}; sat_next = 1'b1;
    end else if (tot < SatMin) begin
      res_next = {1'b1, {(SW-1){1'b0}}}; sat_next = 1'b1;
    end else begin
      res_next = tot[SW-1:0]; sat_next = 1'b0;
    end
  end

  `ASSERT_NR(a_busy_low, clk, !busy, "busy must stay low")
  `ASSERT_CLK(a_lat, clk, rst, $past(vld[DEPTH-1]) == done, "done latency slip")
  `ASSERT_CLK(a_zero, clk, rst, (done && tz_q) |-> (conv_term == '0 && !saturated),
    "unused command gave a value")
  `ASSERT_CLK(a_satv, clk, rst, (done && saturated) |->
    (conv_term == {1'b0, {(SW-1){1'b1}}} || conv_term == {1'b1, {(SW-1){1'b0}}}),
    "saturated value out of place")
  `ASSERT_CLK(a_tot, clk, rst, (done && !saturated && !tz_q) |->
    (conv_term == tq2[SW-1:0]), "unsaturated value mismatch")
endmodule

### rtl/dcc_dir.sv
// One direction of the donor-cell term, a pipeline of six register stages
module dcc_dir #(
  parameter int SW = dcc_pkg::SampleWidthDef,
  parameter int FB = dcc_pkg::FracBitsDef
) (
  input  logic                                clk,
  input  logic signed [SW+1:0]                f1,
  input  logic signed [SW+1:0]                m1,
  input  logic signed [SW+1:0]                d1,
  input  logic signed [SW+1:0]                f2,
  input  logic signed [SW+1:0]                m2,
  input  logic signed [SW+1:0]                d2,
  input  logic [dcc_pkg::GammaWidth-1:0]      gamma,
  input  logic [dcc_pkg::RecipWidth-1:0]      recip,
  output logic signed [2*SW+dcc_pkg::RecipWidth+8:0] term
);
  import dcc_pkg::*;
  localparam int PW = 2*SW + 5;
  localparam int BW = PW + GammaWidth + 2;
  localparam int RS = FB + GammaFrac;
  localparam int TW = 2*SW + RecipWidth + 9;
  localparam int QS = RecipFrac + QuarterShift;
  localparam int QW = BW - RS + 1;
  localparam int LW = QW / 2;
  localparam int HW = QW - LW;

  logic signed [PW-1:0] c1, c2, u1, u2;
  logic signed [GammaWidth:0] g1;
  logic [RecipWidth-1:0] r1, r2, r3, r4;
  logic signed [PW:0] cen, up;
  logic signed [GammaWidth:0] g2;
  logic signed [BW-1:0] b3;
  logic signed [BW-RS:0] r_q;
  logic [LW+RecipWidth-1:0] p_lo;
  logic signed [HW+RecipWidth:0] p_hi;
  logic signed [TW-1:0] prod;
  logic signed [BW:0] bsum;

  always_ff @(posedge clk) begin
    c1 <= PW'(f1) * PW'(m1);
    c2 <= PW'(f2) * PW'(m2);
    u1 <= PW'(f1 < 0 ? -f1 : f1) * PW'(d1);
    u2 <= PW'(f2 < 0 ? -f2 : f2) * PW'(d2);
    g1 <= {1'b0, gamma};
    r1 <= recip;
    cen <= (PW+1)'(c1) - (PW+1)'(c2);
    up  <= (PW+1)'(u1) - (PW+1)'(u2);
    g2 <= g1;
    r2 <= r1;
    b3 <= BW'(cen) * BW'(2**GammaFrac) + BW'(up) * BW'(g2);
    r3 <= r2;
    r4 <= r3;
    r_q <= bsum[BW:RS];
    p_lo <= (LW+RecipWidth)'(r_q[LW-1:0]) * (LW+RecipWidth)'(r4);
    p_hi <= (HW+RecipWidth+1)'($signed(r_q[QW-1:LW])) *
            (HW+RecipWidth+1)'($signed({1'b0, r4}));
    prod <= (TW'(p_hi) <<< LW) + $signed(TW'(p_lo));
  end

  assign bsum = (BW+1)'(b3) + ((BW+1)'(1) <<< (RS-1));
  always_comb term = (TW'(prod) + TW'(2**(QS-1))) >>> QS;
endmodule
